// ----- src/wgsp_pkg.sv -----
// Shared types and constants for the weighted graph shortest path block.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package wgsp_pkg;

    localparam int DIST_BITS = 22;
    localparam logic [DIST_BITS-1:0] DIST_MAX = 22'h3F_FFFF;
    localparam int VTX_BITS = 6;
    localparam int IN_WEIGHT_BITS = 16;

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_SET     = 3'd1,
        OP_REMOVE  = 3'd2,
        OP_PATH    = 3'd3,
        OP_NEAREST = 3'd4
    } op_t;

    typedef enum logic [10:0] {
        S_CLEAR   = 11'b00000000001,
        S_IDLE    = 11'b00000000010,
        S_EDGE_WR = 11'b00000000100,
        S_SP_SEL  = 11'b00000001000,
        S_SP_RLX  = 11'b00000010000,
        S_BT_RD   = 11'b00000100000,
        S_BT_WAIT = 11'b00001000000,
        S_EM_RD   = 11'b00010000000,
        S_EM_LD   = 11'b00100000000,
        S_NN_SCAN = 11'b01000000000,
        S_OUT     = 11'b10000000000
    } state_t;

    localparam state_t S_NN_FIN_RET = S_IDLE;

endpackage

// ----- src/weighted_graph_shortest_path_top.sv -----
// Directed weighted graph store with shortest path and nearest neighbour queries. After
// reset the block sweeps the edge memory clear, one entry a cycle (all 2**(2*clog2(V))
// entries, 4096 by default), with in_stall high. An edge operation reads the entry, then
// writes it back. A shortest path query runs selection and relaxation sweeps over the
// vertex memory, once per settled vertex, then walks the parent links back from the target
// to the source and hands the path out one result beat at a time, each beat held while
// out_stall is high. A nearest neighbour query runs one sweep per reported neighbour, one
// more sweep when the neighbours run out before the limit, and hands out its result beats.
// Each memory has a single read port; one item is worked at a time. Depends on wgsp_pkg
// and wgsp_ram.
`timescale 1ns / 1ps

module weighted_graph_shortest_path_top
    import wgsp_pkg::*;
#(
    parameter int VERTEX_COUNT = 64,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [2:0]                opcode,
    input  logic [VTX_BITS-1:0]       from_vertex,
    input  logic [VTX_BITS-1:0]       to_vertex,
    input  logic [IN_WEIGHT_BITS-1:0] weight,
    input  logic [VTX_BITS-1:0]       count_limit,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [VTX_BITS-1:0]       vertex,
    output logic [DIST_BITS-1:0]      distance,
    output logic                      found,
    output logic                      last
);

    localparam int VB     = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam int CW     = $clog2(VERTEX_COUNT + 1);
    localparam int EA     = 2 * VB;
    localparam int EDEPTH = 1 << EA;
    localparam int EW     = (WEIGHT_BITS < IN_WEIGHT_BITS) ? WEIGHT_BITS : IN_WEIGHT_BITS;
    localparam logic [CW-1:0] VC_C = CW'(VERTEX_COUNT);

    state_t state_reg, state_next, ret_reg, ret_next;
    logic [EA-1:0]          clr_reg, clr_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic                   pv_reg, pv_next;
    logic [VB-1:0]          pidx_reg, pidx_next;
    logic [VB-1:0]          src_reg, src_next, dst_reg, dst_next, cur_reg, cur_next;
    logic [DIST_BITS-1:0]   bestd_reg, bestd_next;
    logic                   have_reg, have_next;
    logic [VB-1:0]          bi_reg, bi_next;
    logic [VERTEX_COUNT-1:0] vis_reg, vis_next, dval_reg, dval_next;
    logic [CW-1:0]          n_reg, n_next;
    logic [VTX_BITS-1:0]    lim_reg, lim_next;
    logic [VTX_BITS:0]      cnt_reg, cnt_next;
    logic                   pend_v_reg, pend_v_next;
    logic [VB-1:0]          pend_vtx_reg, pend_vtx_next;
    logic [EW-1:0]          pend_w_reg, pend_w_next;
    logic [2:0]             op_reg, op_next;
    logic [EW-1:0]          w_reg, w_next;
    logic [EA-1:0]          ea_reg, ea_next;
    logic [VTX_BITS-1:0]    vertex_reg, vertex_next;
    logic [DIST_BITS-1:0]   distance_reg, distance_next;
    logic                   found_reg, found_next, last_reg, last_next;

    // edge memory: {present, weight}
    logic            e_we;
    logic [EA-1:0]   e_waddr, e_raddr;
    logic [EW:0]     e_wdata, e_rdata;
    // vertex memory: {distance, parent}
    logic                  v_we;
    logic [VB-1:0]         v_waddr, v_raddr;
    logic [DIST_BITS+VB-1:0] v_wdata, v_rdata;
    // path memory: {vertex, distance}
    logic                  p_we;
    logic [VB-1:0]         p_waddr, p_raddr;
    logic [VB+DIST_BITS-1:0] p_wdata, p_rdata;

    logic                  in_acc;
    logic                  a_bad, b_bad;
    logic [DIST_BITS-1:0]  v_dist, nd;
    logic [VB-1:0]         v_par;
    logic [DIST_BITS:0]    sum;
    logic                  sweep_end;

    wgsp_ram #(.WIDTH(EW + 1), .DEPTH(EDEPTH)) u_edge_ram (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata)
    );

    wgsp_ram #(.WIDTH(DIST_BITS + VB), .DEPTH(1 << VB)) u_vtx_ram (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rdata)
    );

    wgsp_ram #(.WIDTH(VB + DIST_BITS), .DEPTH(1 << VB)) u_path_ram (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = (state_reg == S_OUT);
    assign vertex    = vertex_reg;
    assign distance  = distance_reg;
    assign found     = found_reg;
    assign last      = last_reg;

    assign a_bad  = ({1'b0, from_vertex} >= 7'(VERTEX_COUNT));
    assign b_bad  = ({1'b0, to_vertex} >= 7'(VERTEX_COUNT));
    assign v_dist = v_rdata[DIST_BITS+VB-1:VB];
    assign v_par  = v_rdata[VB-1:0];
    assign sum    = {1'b0, bestd_reg} + (DIST_BITS + 1)'(e_rdata[EW-1:0]);
    assign nd     = (sum > {1'b0, DIST_MAX}) ? DIST_MAX : sum[DIST_BITS-1:0];
    assign sweep_end = (idx_reg == VC_C) && !pv_reg;

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        clr_next      = clr_reg;
        idx_next      = idx_reg;
        pv_next       = pv_reg;
        pidx_next     = pidx_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        cur_next      = cur_reg;
        bestd_next    = bestd_reg;
        have_next     = have_reg;
        bi_next       = bi_reg;
        vis_next      = vis_reg;
        dval_next     = dval_reg;
        n_next        = n_reg;
        lim_next      = lim_reg;
        cnt_next      = cnt_reg;
        pend_v_next   = pend_v_reg;
        pend_vtx_next = pend_vtx_reg;
        pend_w_next   = pend_w_reg;
        op_next       = op_reg;
        w_next        = w_reg;
        ea_next       = ea_reg;
        vertex_next   = vertex_reg;
        distance_next = distance_reg;
        found_next    = found_reg;
        last_next     = last_reg;

        e_we    = 1'b0;
        e_waddr = ea_reg;
        e_wdata = '0;
        e_raddr = {from_vertex[VB-1:0], to_vertex[VB-1:0]};
        v_we    = 1'b0;
        v_waddr = pidx_reg;
        v_wdata = {nd, cur_reg};
        v_raddr = idx_reg[VB-1:0];
        p_we    = 1'b0;
        p_waddr = n_reg[VB-1:0];
        p_wdata = {cur_reg, v_dist};
        p_raddr = VB'(n_reg - CW'(1));

        // advance a read sweep over vertex indexes
        if (state_reg == S_SP_SEL || state_reg == S_SP_RLX || state_reg == S_NN_SCAN)
        begin
            pv_next   = (idx_reg != VC_C);
            pidx_next = idx_reg[VB-1:0];
            if (idx_reg != VC_C)
            begin
                idx_next = idx_reg + CW'(1);
            end
        end

        case (state_reg)
            S_CLEAR:
            begin
                e_we     = 1'b1;
                e_waddr  = clr_reg;
                clr_next = clr_reg + EA'(1);
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    op_next  = opcode;
                    w_next   = weight[EW-1:0];
                    ea_next  = {from_vertex[VB-1:0], to_vertex[VB-1:0]};
                    src_next = from_vertex[VB-1:0];
                    dst_next = to_vertex[VB-1:0];
                    lim_next = count_limit;
                    idx_next = '0;
                    pv_next  = 1'b0;
                    have_next = 1'b0;
                    // not-found beat, used by the query paths below
                    vertex_next   = '0;
                    distance_next = '0;
                    found_next    = 1'b0;
                    last_next     = 1'b1;
                    ret_next      = S_IDLE;
                    if (opcode == OP_ADD || opcode == OP_SET || opcode == OP_REMOVE)
                    begin
                        if (!a_bad && !b_bad)
                        begin
                            state_next = S_EDGE_WR;
                        end
                    end
                    else if (opcode == OP_PATH)
                    begin
                        if (a_bad || b_bad)
                        begin
                            state_next = S_OUT;
                        end
                        else
                        begin
                            vis_next  = '0;
                            dval_next = '0;
                            dval_next[from_vertex[VB-1:0]] = 1'b1;
                            v_we      = 1'b1;
                            v_waddr   = from_vertex[VB-1:0];
                            v_wdata   = '0;
                            state_next = S_SP_SEL;
                        end
                    end
                    else if (opcode == OP_NEAREST)
                    begin
                        if (a_bad || count_limit == '0)
                        begin
                            state_next = S_OUT;
                        end
                        else
                        begin
                            vis_next    = '0;
                            cnt_next    = '0;
                            pend_v_next = 1'b0;
                            state_next  = S_NN_SCAN;
                        end
                    end
                end
            end
            S_EDGE_WR:
            begin
                e_waddr = ea_reg;
                if (op_reg == OP_ADD)
                begin
                    e_we    = !e_rdata[EW];
                    e_wdata = {1'b1, w_reg};
                end
                else if (op_reg == OP_SET)
                begin
                    e_we    = e_rdata[EW];
                    e_wdata = {1'b1, w_reg};
                end
                else
                begin
                    e_we    = 1'b1;
                    e_wdata = {1'b0, e_rdata[EW-1:0]};
                end
                state_next = S_IDLE;
            end
            S_SP_SEL:
            begin
                if (pv_reg && dval_reg[pidx_reg] && !vis_reg[pidx_reg]
                    && (!have_reg || v_dist < bestd_reg))
                begin
                    have_next  = 1'b1;
                    bestd_next = v_dist;
                    bi_next    = pidx_reg;
                end
                if (sweep_end)
                begin
                    idx_next = '0;
                    pv_next  = 1'b0;
                    if (!have_reg)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        vis_next[bi_reg] = 1'b1;
                        cur_next = bi_reg;
                        if (bi_reg == dst_reg)
                        begin
                            n_next     = '0;
                            state_next = S_BT_RD;
                        end
                        else
                        begin
                            state_next = S_SP_RLX;
                        end
                    end
                end
            end
            S_SP_RLX:
            begin
                e_raddr = {cur_reg, idx_reg[VB-1:0]};
                if (pv_reg && e_rdata[EW] && (!dval_reg[pidx_reg] || nd < v_dist))
                begin
                    v_we = 1'b1;
                    dval_next[pidx_reg] = 1'b1;
                end
                if (sweep_end)
                begin
                    idx_next   = '0;
                    pv_next    = 1'b0;
                    have_next  = 1'b0;
                    state_next = S_SP_SEL;
                end
            end
            S_BT_RD:
            begin
                v_raddr    = cur_reg;
                state_next = S_BT_WAIT;
            end
            S_BT_WAIT:
            begin
                p_we   = 1'b1;
                n_next = n_reg + CW'(1);
                if (cur_reg == src_reg)
                begin
                    state_next = S_EM_RD;
                end
                else
                begin
                    cur_next   = v_par;
                    state_next = S_BT_RD;
                end
            end
            S_EM_RD:
            begin
                n_next     = n_reg - CW'(1);
                state_next = S_EM_LD;
            end
            S_EM_LD:
            begin
                vertex_next   = VTX_BITS'(p_rdata[VB+DIST_BITS-1:DIST_BITS]);
                distance_next = p_rdata[DIST_BITS-1:0];
                found_next    = 1'b1;
                last_next     = (n_reg == '0);
                ret_next      = (n_reg == '0) ? S_IDLE : S_EM_RD;
                state_next    = S_OUT;
            end
            S_NN_SCAN:
            begin
                e_raddr = {src_reg, idx_reg[VB-1:0]};
                // best weight of the scan so far is kept in bestd_reg
                if (pv_reg && e_rdata[EW] && !vis_reg[pidx_reg]
                    && (!have_reg || e_rdata[EW-1:0] < bestd_reg[EW-1:0]))
                begin
                    have_next  = 1'b1;
                    bestd_next = DIST_BITS'(e_rdata[EW-1:0]);
                    bi_next    = pidx_reg;
                end
                if (sweep_end)
                begin
                    idx_next  = '0;
                    pv_next   = 1'b0;
                    have_next = 1'b0;
                    if (have_reg)
                    begin
                        vis_next[bi_reg] = 1'b1;
                        cnt_next      = cnt_reg + (VTX_BITS + 1)'(1);
                        pend_v_next   = 1'b1;
                        pend_vtx_next = bi_reg;
                        pend_w_next   = bestd_reg[EW-1:0];
                        if (pend_v_reg)
                        begin
                            // hand out the previous neighbour, more follow
                            vertex_next   = VTX_BITS'(pend_vtx_reg);
                            distance_next = DIST_BITS'(pend_w_reg);
                            found_next    = 1'b1;
                            last_next     = 1'b0;
                            ret_next      = S_NN_SCAN;
                            state_next    = S_OUT;
                        end
                        if (cnt_reg + (VTX_BITS + 1)'(1) == {1'b0, lim_reg})
                        begin
                            // limit hit: hand out the remaining beats and finish
                            vertex_next   = pend_v_reg ? VTX_BITS'(pend_vtx_reg)
                                                       : VTX_BITS'(bi_reg);
                            distance_next = pend_v_reg ? DIST_BITS'(pend_w_reg)
                                                       : bestd_reg;
                            found_next    = 1'b1;
                            last_next     = !pend_v_reg;
                            pend_v_next   = pend_v_reg;
                            pend_vtx_next = bi_reg;
                            pend_w_next   = bestd_reg[EW-1:0];
                            ret_next      = S_IDLE;
                            state_next    = S_OUT;
                            if (pend_v_reg)
                            begin
                                ret_next = S_EM_LD;
                                n_next   = '0;
                            end
                        end
                    end
                    else
                    begin
                        vertex_next   = pend_v_reg ? VTX_BITS'(pend_vtx_reg) : '0;
                        distance_next = pend_v_reg ? DIST_BITS'(pend_w_reg) : '0;
                        found_next    = pend_v_reg;
                        last_next     = 1'b1;
                        ret_next      = S_IDLE;
                        state_next    = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ret_reg;
                    // final neighbour beat after a limit stop
                    if (ret_reg == S_EM_LD && op_reg == OP_NEAREST)
                    begin
                        vertex_next   = VTX_BITS'(pend_vtx_reg);
                        distance_next = DIST_BITS'(pend_w_reg);
                        found_next    = 1'b1;
                        last_next     = 1'b1;
                        ret_next      = S_NN_FIN_RET;
                        state_next    = S_OUT;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            ret_reg    <= S_IDLE;
            clr_reg    <= '0;
            idx_reg    <= '0;
            pv_reg     <= 1'b0;
            have_reg   <= 1'b0;
            vis_reg    <= '0;
            dval_reg   <= '0;
            n_reg      <= '0;
            cnt_reg    <= '0;
            pend_v_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            clr_reg    <= clr_next;
            idx_reg    <= idx_next;
            pv_reg     <= pv_next;
            have_reg   <= have_next;
            vis_reg    <= vis_next;
            dval_reg   <= dval_next;
            n_reg      <= n_next;
            cnt_reg    <= cnt_next;
            pend_v_reg <= pend_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg     <= pidx_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        cur_reg      <= cur_next;
        bestd_reg    <= bestd_next;
        bi_reg       <= bi_next;
        lim_reg      <= lim_next;
        pend_vtx_reg <= pend_vtx_next;
        pend_w_reg   <= pend_w_next;
        op_reg       <= op_next;
        w_reg        <= w_next;
        ea_reg       <= ea_next;
        vertex_reg   <= vertex_next;
        distance_reg <= distance_next;
        found_reg    <= found_next;
        last_reg     <= last_next;
    end

    a_notfound_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> last)
        else $error("not-found beat without last");

    a_vis_grows: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SP_RLX |=> (vis_reg & $past(vis_reg)) == $past(vis_reg))
        else $error("settled mark dropped during relaxation");

    a_edge_write: assert property (@(posedge clk) disable iff (!rst_n)
        e_we |-> (state_reg == S_CLEAR || state_reg == S_EDGE_WR))
        else $error("edge memory written outside clear or edge update");

    a_path_len: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= VC_C)
        else $error("path length beyond vertex count");

endmodule

// ----- src/wgsp_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module wgsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
